// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== src/msa_pkg.sv =====
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants, request codes and control/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package msa_pkg;

  localparam int CHANNELS  = 8;
  localparam int SEQ_W     = 32;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_FLD_W  = 3;
  localparam int SEQ_FLD_W = 32;
  localparam int TRIM_W    = 32;

  localparam logic REQ_SEQ    = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic upd;        // apply a sequence beat
    logic start;      // finish request taken, init the fold
    logic scan_step;  // fold one channel into max-first / min-last
    logic emit_step;  // load one result into the output register
  } msa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic idx_last;   // channel walk is on the final channel
  } msa_sts_t;

endpackage

`default_nettype wire

// ===== src/msa_ctrl.sv =====
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer: idle/update, channel scan, result emit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module msa_ctrl import msa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     req_type,
  input  wire msa_sts_t sts,
  output msa_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [3:0] cmd_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_FINISH) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.upd = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_step = sts.out_free;
        if (sts.out_free && sts.idx_last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign cmd_bits = {cmd.upd, cmd.start, cmd.scan_step, cmd.emit_step};

  `ASSERT_AT(a_one_cmd, clk, rst, $onehot0(cmd_bits))
  `ASSERT_AT(a_start_scans, clk, rst, cmd.start |=> (state == ST_SCAN))
  `ASSERT_NEVER(a_beat_while_busy, clk, rst, (cmd.upd || cmd.start) && in_stall)

endmodule

`default_nettype wire

// ===== src/msa_dp.sv =====
// ----------------------------------------------------------------------------
// msa_dp
// Per-channel first/latest store, gap flag, fold and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module msa_dp import msa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire msa_cmd_t             cmd,
  output msa_sts_t                  sts,
  input  wire logic [CH_FLD_W-1:0]  channel,
  input  wire logic [SEQ_FLD_W-1:0] seq_number,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CH_FLD_W-1:0]       out_channel,
  output logic [TRIM_W-1:0]         lead_trim,
  output logic [TRIM_W-1:0]         tail_trim,
  output logic                      all_continuous,
  output logic                      last_of_run
);

  logic [SEQ_W-1:0]    first_seen  [CHANNELS];
  logic [SEQ_W-1:0]    latest_seen [CHANNELS];
  logic [CHANNELS-1:0] has_packet;
  logic                gap_found;

  logic [CH_W-1:0]  idx;
  logic             idx_last;
  logic [CH_W-1:0]  ch_idx;
  logic             ch_ok;
  logic [SEQ_W-1:0] seq;
  logic [SEQ_W-1:0] seq_inc;

  logic [SEQ_W-1:0] max_first;
  logic [SEQ_W-1:0] min_last;
  logic             all_ok;
  logic [SEQ_W-1:0] lead_diff;
  logic [SEQ_W-1:0] tail_diff;
  logic             out_free;

  assign ch_idx   = CH_W'(channel);
  assign ch_ok    = (32'(channel) < 32'(CHANNELS));
  assign seq      = SEQ_W'(seq_number);
  assign seq_inc  = latest_seen[ch_idx] + SEQ_W'(1);
  assign idx_last = (idx == CH_W'(CHANNELS - 1));

  // per-channel store; contents only meaningful where has_packet is set
  always_ff @(posedge clk) begin
    if (cmd.upd && ch_ok) begin
      if (!has_packet[ch_idx]) first_seen[ch_idx] <= seq;
      latest_seen[ch_idx] <= seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_packet <= '0;
      gap_found  <= 1'b0;
    end else if (cmd.emit_step && idx_last) begin
      has_packet <= '0;
      gap_found  <= 1'b0;
    end else if (cmd.upd && ch_ok) begin
      has_packet[ch_idx] <= 1'b1;
      if (has_packet[ch_idx] && (seq_inc != seq)) gap_found <= 1'b1;
    end
  end

  // channel walk index, shared by scan and emit
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.start) begin
      idx <= '0;
    end else if (cmd.scan_step || cmd.emit_step) begin
      idx <= idx_last ? '0 : idx + CH_W'(1);
    end
  end

  // fold: latest first number, earliest last number
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      max_first <= '0;
      min_last  <= '1;
      all_ok    <= !gap_found;
    end else if (cmd.scan_step) begin
      if (has_packet[idx]) begin
        if (first_seen[idx] > max_first) max_first <= first_seen[idx];
        if (latest_seen[idx] < min_last) min_last <= latest_seen[idx];
      end else begin
        all_ok <= 1'b0;
      end
    end
  end

  assign lead_diff = max_first - first_seen[idx];
  assign tail_diff = latest_seen[idx] - min_last;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_channel    <= CH_FLD_W'(idx);
      lead_trim      <= has_packet[idx] ? TRIM_W'(lead_diff) : '0;
      tail_trim      <= has_packet[idx] ? TRIM_W'(tail_diff) : '0;
      all_continuous <= all_ok;
      last_of_run    <= idx_last;
    end
  end

  assign sts.out_free = out_free;
  assign sts.idx_last = idx_last;

  `ASSERT_AT(a_emit_needs_slot, clk, rst, cmd.emit_step |-> out_free)
  `ASSERT_AT(a_clear_after_run, clk, rst, (cmd.emit_step && idx_last) |=> (has_packet == '0 && !gap_found))
  `ASSERT_AT(a_scan_wraps, clk, rst, (cmd.scan_step && idx_last) |=> (idx == '0))

endmodule

`default_nettype wire

// ===== src/multichannel_sequence_aligner.sv =====
// ----------------------------------------------------------------------------
// multichannel_sequence_aligner
// Tracks per-channel packet sequence numbers and reports alignment trims.
// ----------------------------------------------------------------------------
// Usage: send one beat per packet with req_type = 0, its channel and its
// sequence number; such a beat is absorbed without a stall and yields no
// result. A beat with req_type = 1 (finish) stalls the input through a scan
// phase (one channel per cycle through the max/min fold) and then an emit
// phase, one result beat per channel in channel order, the last marked by
// last_of_run; a stalled output stretches the emit phase. Each result carries
// lead_trim = max_first - first[ch] and tail_trim = last[ch] - min_last
// (unsigned, wrapping), both zero for a channel that saw no packets, and
// all_continuous, which is 1 only if every channel got packets and each
// kept to consecutive numbers. After the final result is loaded the
// per-channel state is clear and a new capture can start at once, even
// while that last result still waits in the output register. Channel codes
// at or above CHANNELS are dropped silently.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_sequence_aligner import msa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input beats
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 req_type,
  input  wire logic [CH_FLD_W-1:0]  channel,
  input  wire logic [SEQ_FLD_W-1:0] seq_number,
  // result beats
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CH_FLD_W-1:0]       out_channel,
  output logic [TRIM_W-1:0]         lead_trim,
  output logic [TRIM_W-1:0]         tail_trim,
  output logic                      all_continuous,
  output logic                      last_of_run
);

  msa_cmd_t cmd;
  msa_sts_t sts;

  // sequencer: decides what the datapath does each cycle
  msa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, gap detect, fold and the output register
  msa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .channel        (channel),
    .seq_number     (seq_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .lead_trim      (lead_trim),
    .tail_trim      (tail_trim),
    .all_continuous (all_continuous),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire

// ===== tb/msa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_checker
// Watches both sides of the sequence aligner. It tracks per-channel first
// and last sequence numbers from accepted input beats. It predicts the trim
// beats of each finish and compares every accepted result beat with them.
// ----------------------------------------------------------------------------

module msa_checker import msa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic                 req_type,
  input  wire logic [CH_FLD_W-1:0]  channel,
  input  wire logic [SEQ_FLD_W-1:0] seq_number,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [CH_FLD_W-1:0]  out_channel,
  input  wire logic [TRIM_W-1:0]    lead_trim,
  input  wire logic [TRIM_W-1:0]    tail_trim,
  input  wire logic                 all_continuous,
  input  wire logic                 last_of_run,
  output int                        fail_count,
  output int                        trims_pending
);

  typedef struct packed {
    logic [CH_FLD_W-1:0] ch;
    logic [TRIM_W-1:0]   lead;
    logic [TRIM_W-1:0]   tail;
    logic                cont;
    logic                last;
  } trim_beat_t;

  logic [SEQ_W-1:0]    first_seq [CHANNELS];
  logic [SEQ_W-1:0]    last_seq  [CHANNELS];
  logic [CHANNELS-1:0] heard;
  logic                skipped;
  trim_beat_t          trims_due [$];
  int                  errs = 0;

  function automatic void clear_capture();
    for (int i = 0; i < CHANNELS; i++) begin
      first_seq[i] = '0;
      last_seq[i]  = '0;
    end
    heard   = '0;
    skipped = 1'b0;
  endfunction

  function automatic void track_seq(input logic [CH_FLD_W-1:0] ch,
                                    input logic [SEQ_W-1:0] seq);
    if (ch >= CHANNELS) return;
    if (heard[ch]) begin
      if (seq != last_seq[ch] + SEQ_W'(1)) skipped = 1'b1;
    end else begin
      heard[ch]     = 1'b1;
      first_seq[ch] = seq;
    end
    last_seq[ch] = seq;
  endfunction

  // Finish: fold max-first / min-last over channels that saw packets,
  // queue one trim beat per channel, then start a fresh capture.
  function automatic void close_capture();
    logic [SEQ_W-1:0] max_first;
    logic [SEQ_W-1:0] min_last;
    logic [SEQ_W-1:0] d;
    logic             cont;
    trim_beat_t       b;
    max_first = '0;
    min_last  = '1;
    cont      = !skipped;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!heard[i]) begin
        cont = 1'b0;
      end else begin
        if (first_seq[i] > max_first) max_first = first_seq[i];
        if (last_seq[i] < min_last) min_last = last_seq[i];
      end
    end
    for (int i = 0; i < CHANNELS; i++) begin
      b.ch   = CH_FLD_W'(i);
      b.lead = '0;
      b.tail = '0;
      if (heard[i]) begin
        d      = max_first - first_seq[i];
        b.lead = TRIM_W'(d);
        d      = last_seq[i] - min_last;
        b.tail = TRIM_W'(d);
      end
      b.cont = cont;
      b.last = (i == CHANNELS - 1);
      trims_due = {trims_due, b};
    end
    clear_capture();
  endfunction

  function automatic void check_field(input string what, input logic [TRIM_W-1:0] exp_v,
                                      input logic [TRIM_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errs++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    trim_beat_t want;
    if (rst) begin
      clear_capture();
      trims_due.delete();
    end else begin
      // results first: nothing from a finish taken at this edge can be out yet
      if (out_valid && !out_stall) begin
        if (trims_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat: expected none, actual ch %0d lead %h tail %h",
                   $time, out_channel, lead_trim, tail_trim);
        end else begin
          want = trims_due.pop_front();
          check_field("out_channel", TRIM_W'(want.ch), TRIM_W'(out_channel));
          check_field("lead_trim", want.lead, lead_trim);
          check_field("tail_trim", want.tail, tail_trim);
          check_field("all_continuous", TRIM_W'(want.cont), TRIM_W'(all_continuous));
          check_field("last_of_run", TRIM_W'(want.last), TRIM_W'(last_of_run));
        end
      end
      if (in_valid && !in_stall) begin
        if (req_type == REQ_FINISH) close_capture();
        else track_seq(channel, SEQ_W'(seq_number));
      end
    end
    fail_count    <= errs;
    trims_pending <= trims_due.size();
  end

endmodule

// ===== tb/multichannel_sequence_aligner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_sequence_aligner_tb
// Drives capture runs of tagged sequence numbers, each closed by a finish
// beat, into the aligner. A directed opening covers the empty capture, the
// numeric extremes with a wrap through all-ones, and a skipped number. Random
// captures follow with random idling on both sides and one long output
// hold-off. Checking is done by msa_checker; this module gives the verdict.
// ----------------------------------------------------------------------------

module multichannel_sequence_aligner_tb;
  import msa_pkg::*;

  localparam int STIM_ITEMS     = 360;
  localparam int QUIET_LIMIT    = 2000;  // cycles with no beat on either side
  localparam int SQUEEZE_CYCLES = 150;   // long output hold-off
  localparam int DRAIN_CYCLES   = 24;    // drain margin after the pending count empties

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 req_type   = REQ_SEQ;
  logic [CH_FLD_W-1:0]  channel    = '0;
  logic [SEQ_FLD_W-1:0] seq_number = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [CH_FLD_W-1:0]  out_channel;
  logic [TRIM_W-1:0]    lead_trim;
  logic [TRIM_W-1:0]    tail_trim;
  logic                 all_continuous;
  logic                 last_of_run;

  int   fail_count;
  int   trims_pending;
  int   beats_sent   = 0;
  int   quiet_cycles = 0;
  int   hold_left    = 0;
  bit   calm         = 1'b1;  // no idling on either side while set
  logic squeeze      = 1'b0;  // asks the receiver for its long hold-off
  bit   squeezed     = 1'b0;

  always #2 clk = ~clk;

  multichannel_sequence_aligner i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .channel        (channel),
    .seq_number     (seq_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .lead_trim      (lead_trim),
    .tail_trim      (tail_trim),
    .all_continuous (all_continuous),
    .last_of_run    (last_of_run)
  );

  msa_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .channel        (channel),
    .seq_number     (seq_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .lead_trim      (lead_trim),
    .tail_trim      (tail_trim),
    .all_continuous (all_continuous),
    .last_of_run    (last_of_run),
    .fail_count     (fail_count),
    .trims_pending  (trims_pending)
  );

  // Watchdog: a correct run never goes this long without moving a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off
  // on request. The hold-off lets the output register fill during a finish,
  // so the block has to stall its input while beats keep being offered.
  always @(posedge clk) begin
    if (squeeze && !squeezed) begin
      hold_left = SQUEEZE_CYCLES;
      squeezed  = 1'b1;
    end else if (hold_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 10);
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one beat and hold it until taken; sometimes idle afterwards.
  // Valid stays high into the next beat when there is no gap.
  task automatic send_beat(input logic kind, input logic [CH_FLD_W-1:0] ch,
                           input logic [SEQ_FLD_W-1:0] seq);
    in_valid   <= 1'b1;
    req_type   <= kind;
    channel    <= ch;
    seq_number <= seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Finish beat; its channel and number fields carry noise the block ignores.
  task automatic send_finish();
    send_beat(REQ_FINISH, CH_FLD_W'($urandom), $urandom);
  endtask

  // One random capture: mostly consecutive numbers per channel, channels
  // interleaved at random, now and then a skipped, repeated or junk number or a
  // channel that stays silent, closed by a finish.
  task automatic run_capture();
    logic [SEQ_W-1:0] next_seq [CHANNELS];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    int               left [CHANNELS];
    int               total;
    int               c;
    int               pick;
    bit               shared;
    case ($urandom_range(0, 3))
      0:       base = SEQ_W'($urandom_range(0, 40));
      1:       base = '1 - SEQ_W'($urandom_range(0, 40));
      default: base = $urandom;
    endcase
    shared = ($urandom_range(0, 3) != 0);
    total  = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      // aligned captures start near a common base, the rest anywhere
      next_seq[i] = shared ? base + SEQ_W'($urandom_range(0, 20)) : SEQ_W'($urandom);
      left[i]     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      total      += left[i];
    end
    while (total > 0) begin
      c = $urandom_range(0, CHANNELS - 1);
      while (left[c] == 0) c = (c + 1) % CHANNELS;
      pick = $urandom_range(0, 39);
      if (pick == 0) seq = $urandom;
      else if (pick == 1) seq = next_seq[c] + SEQ_W'($urandom_range(2, 3));
      else if (pick == 2) seq = next_seq[c] - SEQ_W'(1);  // repeated number
      else seq = next_seq[c];
      send_beat(REQ_SEQ, CH_FLD_W'(c), SEQ_FLD_W'(seq));
      next_seq[c] = seq + SEQ_W'(1);
      left[c]--;
      total--;
    end
    send_finish();
  endtask

  initial begin
    logic [SEQ_W-1:0] first;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed part, no idling ---
    // finish with no packets anywhere: zero trims, not continuous
    send_finish();

    // every channel, two consecutive numbers: channel 0 starts at zero,
    // the last channel wraps from all-ones to zero, so the run stays
    // continuous while max-first is all-ones and min-last is zero
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (i == 0) first = '0;
        else if (i == CHANNELS - 1) first = '1;
        else first = SEQ_W'(32'h7FFF_FFF0) + SEQ_W'(i * 5);
        send_beat(REQ_SEQ, CH_FLD_W'(i), SEQ_FLD_W'(first + SEQ_W'(pass)));
      end
    end
    send_finish();

    // skipped number on one channel, most channels silent
    send_beat(REQ_SEQ, CH_FLD_W'(3), SEQ_FLD_W'(10));
    send_beat(REQ_SEQ, CH_FLD_W'(3), SEQ_FLD_W'(12));
    send_beat(REQ_SEQ, CH_FLD_W'(5), SEQ_FLD_W'(12));
    send_finish();

    // --- random part ---
    calm = 1'b0;
    squeeze <= 1'b1;
    while (beats_sent < STIM_ITEMS) begin
      // quiet stretches now and then; the tail of the run has no idling
      calm = (beats_sent > STIM_ITEMS - 70) || ($urandom_range(0, 4) == 0);
      run_capture();
    end
    calm = 1'b1;
    in_valid <= 1'b0;

    // the pending count is registered, so it lags behind the last accepted finish
    @(posedge clk);
    while (trims_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== multichannel_sequence_aligner.f =====
+incdir+src
src/msa_pkg.sv
src/msa_ctrl.sv
src/msa_dp.sv
src/multichannel_sequence_aligner.sv
tb/msa_checker.sv
tb/multichannel_sequence_aligner_tb.sv
